// ----- hdl/bat_pkg.sv -----
// ----------------------------------------------------------------------------
// bat_pkg: shared constants and types for the breakpoint address table
// Operation and status codes, field widths and stream packing widths.
// ----------------------------------------------------------------------------
package bat_pkg;

    localparam int DEFAULT_NUM_SLOTS = 8;

    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 32;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 3;

    // stream packing
    localparam int S_TDATA_W = ADDR_W;
    localparam int S_TUSER_W = KIND_W;
    localparam int M_TDATA_W = 40;
    localparam int M_PAD_W   = M_TDATA_W - ADDR_W - SLOT_W;
    localparam int M_TUSER_W = STATUS_W + 1;

    typedef logic [KIND_W-1:0]   kind_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [SLOT_W-1:0]   slot_t;

    localparam kind_t KIND_SET       = 2'd0;
    localparam kind_t KIND_CLEAR     = 2'd1;
    localparam kind_t KIND_CLEAR_ALL = 2'd2;
    localparam kind_t KIND_CHECK     = 2'd3;

    localparam status_t STATUS_OK        = 2'd0;
    localparam status_t STATUS_FULL      = 2'd1;
    localparam status_t STATUS_NOT_FOUND = 2'd2;

endpackage

// ----- hdl/breakpoint_address_table.sv -----
// ----------------------------------------------------------------------------
// breakpoint_address_table
// Table of breakpoint addresses with set, clear, clear-all and PC check.
//
//   channel | dir | tdata                          | tuser
//   s_      | in  | [31:0] address                 | [1:0] kind
//   m_      | out | [31:0] hit_address, [34:32] slot | [1:0] status, [2] hit
//
// One beat per cycle sustained unless the result is stalled; a beat passes
// the input register, then the result register. The compare against all
// slots, the lowest-slot pick and the table update sit between those two
// registers, so each beat sees every update made by the beat before it.
// After reset the table is empty. A stalled result holds the input register;
// s_tready drops only when both registers are full and m_tready is low.
// ----------------------------------------------------------------------------
module breakpoint_address_table #(
    parameter int NUM_SLOTS = bat_pkg::DEFAULT_NUM_SLOTS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bat_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] address
    input  logic [bat_pkg::S_TUSER_W-1:0]   s_tuser,   // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bat_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] hit_address, [34:32] slot
    output logic [bat_pkg::M_TUSER_W-1:0]   m_tuser    // [1:0] status, [2] hit
);
    import bat_pkg::*;

    logic                   in_valid_reg, in_valid_next;
    kind_t                  in_kind_reg;
    logic [ADDR_W-1:0]      in_addr_reg;

    logic                   out_valid_reg, out_valid_next;
    status_t                out_status_reg;
    logic                   out_hit_reg;
    logic [ADDR_W-1:0]      out_haddr_reg;
    slot_t                  out_slot_reg;

    logic [ADDR_W-1:0]      entry_addr_reg [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]   entry_active_reg, entry_active_next;

    logic                   advance;
    logic [NUM_SLOTS-1:0]   match_vec;
    logic                   found, free_any;
    slot_t                  found_slot, free_slot;
    logic [NUM_SLOTS-1:0]   found_oh, free_oh;

    status_t                res_status;
    logic                   res_hit;
    logic [ADDR_W-1:0]      res_haddr;
    slot_t                  res_slot;
    logic [NUM_SLOTS-1:0]   set_oh, clr_oh;
    logic                   clr_all;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            match_vec[i] = entry_active_reg[i] && (entry_addr_reg[i] == in_addr_reg);
        end
    end

    // walk downwards so the lowest slot wins
    always_comb begin
        found      = 1'b0;
        found_slot = '0;
        found_oh   = '0;
        free_any   = 1'b0;
        free_slot  = '0;
        free_oh    = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (match_vec[i]) begin
                found       = 1'b1;
                found_slot  = SLOT_W'(i);
                found_oh    = '0;
                found_oh[i] = 1'b1;
            end
            if (!entry_active_reg[i]) begin
                free_any   = 1'b1;
                free_slot  = SLOT_W'(i);
                free_oh    = '0;
                free_oh[i] = 1'b1;
            end
        end
    end

    always_comb begin
        res_status = STATUS_OK;
        res_hit    = 1'b0;
        res_haddr  = '0;
        res_slot   = '0;
        set_oh     = '0;
        clr_oh     = '0;
        clr_all    = 1'b0;
        unique case (in_kind_reg)
            KIND_SET: begin
                if (found) begin
                    res_slot = found_slot;
                end else if (free_any) begin
                    set_oh   = free_oh;
                    res_slot = free_slot;
                end else begin
                    res_status = STATUS_FULL;
                end
            end
            KIND_CLEAR: begin
                if (found) begin
                    clr_oh   = found_oh;
                    res_slot = found_slot;
                end else begin
                    res_status = STATUS_NOT_FOUND;
                end
            end
            KIND_CLEAR_ALL: begin
                clr_all = 1'b1;
            end
            KIND_CHECK: begin
                if (found) begin
                    res_hit   = 1'b1;
                    res_haddr = in_addr_reg;
                    res_slot  = found_slot;
                end
            end
        endcase
    end

    always_comb begin
        in_valid_next = s_tready ? s_tvalid : in_valid_reg;

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end

        entry_active_next = entry_active_reg;
        if (advance) begin
            if (clr_all) begin
                entry_active_next = '0;
            end else begin
                entry_active_next = (entry_active_reg | set_oh) & ~clr_oh;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
            entry_active_reg <= '0;
        end else begin
            in_valid_reg     <= in_valid_next;
            out_valid_reg    <= out_valid_next;
            entry_active_reg <= entry_active_next;
        end
    end

    // payload: no reset; stored addresses only matter while their slot is active
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_kind_reg <= kind_t'(s_tuser[KIND_W-1:0]);
            in_addr_reg <= s_tdata[ADDR_W-1:0];
        end
        if (advance) begin
            out_status_reg <= res_status;
            out_hit_reg    <= res_hit;
            out_haddr_reg  <= res_haddr;
            out_slot_reg   <= res_slot;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (set_oh[i]) begin
                    entry_addr_reg[i] <= in_addr_reg;
                end
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {M_PAD_W'(0), out_slot_reg, out_haddr_reg};
    assign m_tuser  = {out_hit_reg, out_status_reg};

endmodule

// ----- hdl/bat_checker.sv -----
// ----------------------------------------------------------------------------
// bat_checker: port-level checks for the breakpoint address table
// Watches the result channel and flags inconsistent result beats.
// ----------------------------------------------------------------------------
module bat_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [bat_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] hit_address, [34:32] slot
    input logic [bat_pkg::M_TUSER_W-1:0]   m_tuser    // [1:0] status, [2] hit
);
    import bat_pkg::*;

    // nothing left over from before reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result beat straight after reset");

    // a hit only comes with status ok
    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STATUS_W] |-> m_tuser[STATUS_W-1:0] == STATUS_OK)
        else $error("hit with error status");

    // without a hit the hit address is zero
    a_nohit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[STATUS_W] |-> m_tdata[ADDR_W-1:0] == '0)
        else $error("hit address set without a hit");

    // failed set or clear reports slot zero
    a_err_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[STATUS_W-1:0] != STATUS_OK
            |-> m_tdata[ADDR_W+SLOT_W-1:ADDR_W] == '0 && !m_tuser[STATUS_W])
        else $error("error beat carries a slot or hit");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

endmodule

bind breakpoint_address_table bat_checker u_bat_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
